// ----- hw/rtl/pdf_pkg.sv -----
// shared types, constants and the byte-wide crc16 update for the frame checker
// no dependencies
`timescale 1ns / 1ps

package pdf_pkg;

  // byte counter width
  localparam int COUNT_BITS = 12;
  localparam int LEN_W = (COUNT_BITS + 1 > 12) ? COUNT_BITS + 1 : 12;

  localparam int HEADER_LEN = 12;
  localparam int CRC_LEN = 2;
  localparam int MIN_LEN = HEADER_LEN + CRC_LEN;

  // header byte positions
  localparam logic [COUNT_BITS-1:0] POS_MAGIC_LO = COUNT_BITS'(0);
  localparam logic [COUNT_BITS-1:0] POS_MAGIC_HI = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] POS_SRC_FIRST = COUNT_BITS'(2);
  localparam logic [COUNT_BITS-1:0] POS_SRC_LAST = COUNT_BITS'(7);
  localparam logic [COUNT_BITS-1:0] POS_HOP = COUNT_BITS'(8);
  localparam logic [COUNT_BITS-1:0] POS_ID_LO = COUNT_BITS'(9);
  localparam logic [COUNT_BITS-1:0] POS_ID_HI = COUNT_BITS'(10);
  localparam logic [COUNT_BITS-1:0] POS_TYPE = COUNT_BITS'(11);
  localparam logic [COUNT_BITS-1:0] POS_PAYLOAD = COUNT_BITS'(MIN_LEN);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd200;

  // configuration register indexes
  localparam logic CFG_MAGIC_WORD = 1'b0;
  localparam logic CFG_MAX_PAYLOAD = 1'b1;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_BAD_CRC   = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_t;

  // one accepted byte's worth of results: a payload beat, a report, or both
  typedef struct packed {
    logic        has_pay;
    logic [7:0]  pay_byte;
    logic        has_rep;
    status_t     status;
    logic [47:0] source_id;
    logic [7:0]  hop_count;
    logic [15:0] packet_id;
    logic [7:0]  packet_type;
    logic [11:0] payload_length;
  } rec_t;

  // output beat, laid out as on the master tdata
  typedef struct packed {
    logic        pad;
    logic [11:0] payload_length;
    logic [7:0]  packet_type;
    logic [15:0] packet_id;
    logic [7:0]  hop_count;
    logic [47:0] source_id;
    logic [2:0]  frame_status;
    logic [7:0]  payload_byte;
  } beat_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/pdf_result_queue.sv -----
// two-entry record queue that splits each record into one or two output beats
// depends on pdf_pkg
`timescale 1ns / 1ps

module pdf_result_queue
  import pdf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  rec_t         push_rec,
  output logic         has_room,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // payload_byte, frame_status, source_id, hop_count,
                                       // packet_id, packet_type, payload_length, zero pad
  output logic         m_axis_tuser,   // result_kind
  output logic         m_axis_tlast    // run_last
);

  rec_t        entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        phase;   // payload beat of the head record already sent
  rec_t        head;
  logic        pay_beat;
  logic        out_fire;
  logic        pop;
  beat_t       beat;

  assign head = entry[rd_ptr];
  assign pay_beat = head.has_pay && !phase;
  assign m_axis_tvalid = (count != 2'd0);
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign pop = out_fire && (!pay_beat || !head.has_rep);
  assign has_room = (count != 2'd2);

  always_comb begin
    beat = '0;
    if (pay_beat) begin
      beat.payload_byte = head.pay_byte;
    end else begin
      beat.frame_status = head.status;
      beat.source_id = head.source_id;
      beat.hop_count = head.hop_count;
      beat.packet_id = head.packet_id;
      beat.packet_type = head.packet_type;
      beat.payload_length = head.payload_length;
    end
  end

  assign m_axis_tdata = beat;
  assign m_axis_tuser = pay_beat ? KIND_PAYLOAD : KIND_REPORT;
  assign m_axis_tlast = !pay_beat || !head.has_rep;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
      phase <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
        phase <= 1'b0;
      end else if (out_fire) begin
        phase <= 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range : assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result queue count out of range");

  a_phase_needs_head : assert property (@(posedge clk) disable iff (rst)
    phase |-> (count != 2'd0) && head.has_pay && head.has_rep)
    else $error("second beat pending without a two-beat head record");

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) |-> !push)
    else $error("push into full result queue");

  a_count_follows : assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 2'd1)
    else $error("queue count missed a push");
`endif

endmodule

// ----- hw/rtl/packet_deframer_crc16_check.sv -----
// frame checker top level: header capture, crc16 check, payload forwarding
// depends on pdf_pkg and pdf_result_queue
`timescale 1ns / 1ps

// Takes one frame byte per cycle on s_axis (tlast marks the final byte) and
// checks a 12-byte header, the payload and a trailing little-endian CRC16
// (poly 0x1021, init 0xFFFF). From the fifteenth byte on, each byte releases
// the payload byte two positions back; the final byte also releases an end of
// frame report (tuser high) with status and, when the status is ok, the header
// fields and payload length. Every byte is processed in the cycle it is
// accepted and its results reach m_axis from the next cycle on, through a
// two-record queue. The final byte of a frame of fifteen or more bytes yields
// two output beats (payload beat, then report); s_axis_tready drops whenever
// the queue holds two records, so even with m_axis always ready the input
// stalls when a one-byte frame directly follows such a frame. Configuration
// writes on cfg_we take effect at the next edge and must be made while idle.

module packet_deframer_crc16_check
  import pdf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // rx_byte
  input  logic         s_axis_tlast,   // end_of_frame
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // payload_byte, frame_status, source_id, hop_count,
                                       // packet_id, packet_type, payload_length, zero pad
  output logic         m_axis_tuser,   // result_kind
  output logic         m_axis_tlast,   // run_last
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_wdata
);

  logic [15:0]           magic_word;
  logic [11:0]           max_payload;

  logic [COUNT_BITS-1:0] byte_index;
  logic [15:0]           crc;
  logic [15:0]           crc_next;
  logic [7:0]            delay0;
  logic [7:0]            delay1;
  logic [15:0]           magic_seen;
  logic [5:0][7:0]       source_hold;
  logic [7:0]            hop_hold;
  logic [15:0]           id_hold;
  logic [7:0]            type_hold;

  logic                  in_fire;
  logic                  has_room;
  logic [2:0]            src_sel;
  logic [LEN_W-1:0]      frame_len;
  logic [LEN_W-1:0]      plen;
  logic [15:0]           declared;
  status_t               status;
  rec_t                  rec;
  logic                  push;

  assign s_axis_tready = has_room;
  assign in_fire = s_axis_tvalid && has_room;

  assign src_sel = byte_index[2:0] - 3'd2;
  assign crc_next = (byte_index >= POS_SRC_FIRST) ? crc_feed(crc, delay0) : crc;

  // length checks on the final byte
  assign frame_len = LEN_W'(byte_index) + LEN_W'(1);
  assign plen = frame_len - LEN_W'(MIN_LEN);
  assign declared = {s_axis_tdata, delay1};

  always_comb begin
    if (frame_len < LEN_W'(MIN_LEN)) begin
      status = ST_TOO_SHORT;
    end else if (magic_seen != magic_word) begin
      status = ST_BAD_MAGIC;
    end else if (crc_next != declared) begin
      status = ST_BAD_CRC;
    end else if (plen > LEN_W'(max_payload)) begin
      status = ST_TOO_LONG;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    rec = '0;
    rec.has_pay = (byte_index >= POS_PAYLOAD);
    rec.pay_byte = delay0;
    rec.has_rep = s_axis_tlast;
    rec.status = status;
    if (status == ST_OK) begin
      rec.source_id = source_hold;
      rec.hop_count = hop_hold;
      rec.packet_id = id_hold;
      rec.packet_type = type_hold;
      rec.payload_length = (plen > LEN_W'(12'hFFF)) ? 12'hFFF : plen[11:0];
    end
  end

  assign push = in_fire && (rec.has_pay || rec.has_rep);

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word <= 16'd0;
      max_payload <= MAX_PAYLOAD_RST[11:0];
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAGIC_WORD:  magic_word <= cfg_wdata;
        CFG_MAX_PAYLOAD: max_payload <= cfg_wdata[11:0];
        default:         magic_word <= magic_word;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
      crc <= CRC_INIT;
    end else if (in_fire) begin
      if (s_axis_tlast) begin
        byte_index <= '0;
        crc <= CRC_INIT;
      end else begin
        crc <= crc_next;
        if (byte_index != COUNT_MAX) begin
          byte_index <= byte_index + COUNT_BITS'(1);
        end
      end
    end
  end

  // header holds and the two-byte delay line
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (!s_axis_tlast) begin
        delay0 <= delay1;
        delay1 <= s_axis_tdata;
      end
      if (byte_index == POS_MAGIC_LO) begin
        magic_seen[7:0] <= s_axis_tdata;
      end
      if (byte_index == POS_MAGIC_HI) begin
        magic_seen[15:8] <= s_axis_tdata;
      end
      if (byte_index >= POS_SRC_FIRST && byte_index <= POS_SRC_LAST) begin
        source_hold[src_sel] <= s_axis_tdata;
      end
      if (byte_index == POS_HOP) begin
        hop_hold <= s_axis_tdata;
      end
      if (byte_index == POS_ID_LO) begin
        id_hold[7:0] <= s_axis_tdata;
      end
      if (byte_index == POS_ID_HI) begin
        id_hold[15:8] <= s_axis_tdata;
      end
      if (byte_index == POS_TYPE) begin
        type_hold <= s_axis_tdata;
      end
    end
  end

  pdf_result_queue u_queue (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .push_rec      (rec),
    .has_room      (has_room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_restart_after_eof : assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_axis_tlast) |=> (byte_index == '0) && (crc == CRC_INIT))
    else $error("frame state not restarted after final byte");

  a_report_on_eof : assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_axis_tlast) |-> push && rec.has_rep)
    else $error("final byte did not queue a report");

  a_count_advances : assert property (@(posedge clk) disable iff (rst)
    (in_fire && !s_axis_tlast && byte_index != COUNT_MAX)
      |=> byte_index == $past(byte_index) + COUNT_BITS'(1))
    else $error("byte counter did not advance");
`endif

endmodule

// ----- dv/packet_deframer_crc16_check_tb.sv -----
// testbench for the frame checker: drives framed byte streams with random gaps,
// predicts payload beats and end-of-frame reports, and checks them in order
// depends on pdf_pkg and the packet_deframer_crc16_check rtl
`timescale 1ns / 1ps

import pdf_pkg::*;

// one expected output beat, unpacked into the result fields
typedef struct packed {
  logic        kind;
  logic [7:0]  pay;
  status_t     status;
  logic [47:0] src;
  logic [7:0]  hop;
  logic [15:0] pid;
  logic [7:0]  ptype;
  logic [11:0] plen;
  logic        last;
} frame_beat_t;

// crc16-ccitt, one byte, msb first
function automatic logic [15:0] ccitt_next(logic [15:0] c, logic [7:0] b);
  logic [15:0] r;
  logic fb;
  r = c;
  for (int i = 7; i >= 0; i--) begin
    fb = r[15] ^ b[i];
    r = {r[14:0], 1'b0};
    if (fb) begin
      r = r ^ CRC_POLY;
    end
  end
  return r;
endfunction

class frame_scoreboard;
  logic [15:0] magic_cfg;
  logic [11:0] max_cfg;

  logic [COUNT_BITS-1:0] pos;
  logic [15:0] crc;
  logic [7:0]  lag0, lag1;
  logic [15:0] magic_got;
  logic [47:0] src_got;
  logic [7:0]  hop_got;
  logic [15:0] pid_got;
  logic [7:0]  type_got;

  frame_beat_t waiting[$];
  int errors;

  function new();
    magic_cfg = '0;
    max_cfg = 12'd200;
    restart();
    magic_got = '0;
    src_got = '0;
    hop_got = '0;
    pid_got = '0;
    type_got = '0;
    errors = 0;
  endfunction

  function void restart();
    pos = '0;
    crc = CRC_INIT;
    lag0 = '0;
    lag1 = '0;
  endfunction

  function void set_reg(logic idx, logic [15:0] v);
    if (idx == CFG_MAGIC_WORD) begin
      magic_cfg = v;
    end else begin
      max_cfg = v[11:0];
    end
  endfunction

  function int pending();
    return waiting.size();
  endfunction

  // one accepted request: update the frame state and queue what it releases
  function void note_byte(logic [7:0] b, logic eof);
    int unsigned p, flen, plen;
    logic [15:0] sent;
    frame_beat_t r;
    p = 32'(pos);
    if (p < HEADER_LEN) begin
      case (pos)
        POS_MAGIC_LO: magic_got[7:0] = b;
        POS_MAGIC_HI: magic_got[15:8] = b;
        POS_HOP:      hop_got = b;
        POS_ID_LO:    pid_got[7:0] = b;
        POS_ID_HI:    pid_got[15:8] = b;
        POS_TYPE:     type_got = b;
        default:      src_got[(p - 2) * 8 +: 8] = b;
      endcase
    end
    // crc and payload see bytes two positions late
    if (p >= 2) begin
      crc = ccitt_next(crc, lag0);
    end
    if (p >= MIN_LEN) begin
      r = '0;
      r.kind = KIND_PAYLOAD;
      r.pay = lag0;
      r.last = !eof;
      waiting.push_back(r);
    end
    if (eof) begin
      r = '0;
      r.kind = KIND_REPORT;
      r.last = 1'b1;
      flen = p + 1;
      if (flen < MIN_LEN) begin
        r.status = ST_TOO_SHORT;
      end else begin
        sent = {b, lag1};
        plen = flen - MIN_LEN;
        if (magic_got != magic_cfg) begin
          r.status = ST_BAD_MAGIC;
        end else if (crc != sent) begin
          r.status = ST_BAD_CRC;
        end else if (plen > 32'(max_cfg)) begin
          r.status = ST_TOO_LONG;
        end else begin
          r.status = ST_OK;
          r.src = src_got;
          r.hop = hop_got;
          r.pid = pid_got;
          r.ptype = type_got;
          r.plen = (plen > 4095) ? 12'hFFF : 12'(plen);
        end
      end
      waiting.push_back(r);
      restart();
    end else begin
      lag0 = lag1;
      lag1 = b;
      if (pos != COUNT_MAX) begin
        pos = pos + COUNT_BITS'(1);
      end
    end
  endfunction

  function void cmp(string what, logic [63:0] exp, logic [63:0] act);
    if (act !== exp) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, exp, act);
      errors++;
    end
  endfunction

  function void check_beat(logic kind, logic [103:0] d, logic last);
    frame_beat_t e;
    if (waiting.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual kind %0d data %h",
               $time, kind, d);
      errors++;
      return;
    end
    e = waiting.pop_front();
    cmp("result_kind", 64'(e.kind), 64'(kind));
    cmp("payload_byte", 64'(e.pay), 64'(d[7:0]));
    cmp("frame_status", 64'(e.status), 64'(d[10:8]));
    cmp("source_id", 64'(e.src), 64'(d[58:11]));
    cmp("hop_count", 64'(e.hop), 64'(d[66:59]));
    cmp("packet_id", 64'(e.pid), 64'(d[82:67]));
    cmp("packet_type", 64'(e.ptype), 64'(d[90:83]));
    cmp("payload_length", 64'(e.plen), 64'(d[102:91]));
    cmp("pad", 64'd0, 64'(d[103]));
    cmp("run_last", 64'(e.last), 64'(last));
  endfunction
endclass

module packet_deframer_crc16_check_tb;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tready = 1'b0;
  logic         cfg_we = 1'b0;
  logic         cfg_index = 1'b0;
  logic [15:0]  cfg_wdata = '0;
  wire          s_axis_tready;
  wire          m_axis_tvalid;
  wire  [103:0] m_axis_tdata;
  wire          m_axis_tuser;
  wire          m_axis_tlast;

  frame_scoreboard sb;
  logic [7:0] frame_q[$];
  bit no_idle = 1'b0;
  int bytes_sent = 0;
  int stall_left = 0;

  always #5 clk = ~clk;

  packet_deframer_crc16_check uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic push_byte(logic [7:0] b, logic eof);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= eof;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_byte(b, eof);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) begin
      push_byte(frame_q[i], i == frame_q.size() - 1);
    end
  endtask

  // header (fill < 0 gives random header bytes), payload, little-endian crc
  task automatic build_frame(bit good_magic, bit good_crc, int plen, int fill);
    logic [15:0] m, c;
    frame_q.delete();
    m = sb.magic_cfg;
    if (!good_magic) begin
      m = m ^ 16'($urandom_range(1, 65535));
    end
    frame_q.push_back(m[7:0]);
    frame_q.push_back(m[15:8]);
    repeat (10) frame_q.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
    repeat (plen) frame_q.push_back(8'($urandom_range(0, 255)));
    c = CRC_INIT;
    foreach (frame_q[i]) begin
      c = ccitt_next(c, frame_q[i]);
    end
    if (!good_crc) begin
      c = c ^ 16'($urandom_range(1, 65535));
    end
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
  endtask

  // drop valid and wait until every expected result is out
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic random_frame();
    int k, n;
    bit eof;
    k = $urandom_range(0, 19);
    if (k < 14) begin
      n = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 20) : $urandom_range(21, 60);
      build_frame($urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0, n, -1);
      send_frame();
    end else if (k < 17) begin
      frame_q.delete();
      repeat ($urandom_range(1, 13)) frame_q.push_back(8'($urandom_range(0, 255)));
      send_frame();
    end else begin
      // noise: random bytes until a random end of frame
      n = 0;
      do begin
        n++;
        eof = ($urandom_range(0, 5) == 0) || (n >= 60);
        push_byte(8'($urandom_range(0, 255)), eof);
      end while (!eof);
    end
  endtask

  task automatic run_phase(int nbytes);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < nbytes) begin
      no_idle = ($urandom_range(0, 6) == 0);
      random_frame();
    end
    no_idle = 1'b0;
  endtask

  // result side: check accepted beats, stall at random
  initial begin
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_beat(m_axis_tuser, m_axis_tdata, m_axis_tlast);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = pick_gap();
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: one-byte frame, longest short frame, minimal good frame
    frame_q.delete();
    frame_q.push_back(8'hFF);
    send_frame();
    frame_q.delete();
    repeat (13) frame_q.push_back(8'($urandom_range(0, 255)));
    send_frame();
    build_frame(1'b1, 1'b1, 0, 8'hFF);
    send_frame();

    // one byte over the reset payload limit, sent back to back
    no_idle = 1'b1;
    build_frame(1'b1, 1'b1, 201, -1);
    send_frame();
    no_idle = 1'b0;

    // upper bits of the write are dropped, giving the largest limit
    write_reg(CFG_MAX_PAYLOAD, 16'hFFFF);
    write_reg(CFG_MAGIC_WORD, 16'($urandom_range(0, 65535)));

    run_phase(150);
    write_reg(CFG_MAGIC_WORD, 16'hFFFF);
    write_reg(CFG_MAX_PAYLOAD, 16'h0000);
    run_phase(150);
    write_reg(CFG_MAGIC_WORD, 16'($urandom_range(0, 65535)));
    write_reg(CFG_MAX_PAYLOAD, 16'($urandom_range(0, 30)));
    run_phase(150);
    write_reg(CFG_MAGIC_WORD, 16'h0000);
    write_reg(CFG_MAX_PAYLOAD, 16'($urandom_range(0, 65535)));
    run_phase(100);
    write_reg(CFG_MAGIC_WORD, 16'($urandom_range(0, 65535)));
    write_reg(CFG_MAX_PAYLOAD, 16'd12);
    run_phase(150);

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("packet_deframer_crc16_check test passed");
    end else begin
      $display("packet_deframer_crc16_check test failed");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("packet_deframer_crc16_check test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/pdf_pkg.sv
hw/rtl/pdf_result_queue.sv
hw/rtl/packet_deframer_crc16_check.sv
dv/packet_deframer_crc16_check_tb.sv
